[design/max_counter_task_scheduler_assert.svh]
// ---------------------------------------------------------------------------
// max_counter_task_scheduler assertion macros
// concurrent assertion helpers sampled on clk_i, disabled while rst_ni is low
// ---------------------------------------------------------------------------
`ifndef MAX_COUNTER_TASK_SCHEDULER_ASSERT_SVH
`define MAX_COUNTER_TASK_SCHEDULER_ASSERT_SVH

// same-cycle implication
`define MCTS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("scheduler assertion failed");

// next-cycle implication
`define MCTS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("scheduler assertion failed");

`endif

[design/mcts_pkg.sv]
// ---------------------------------------------------------------------------
// mcts_pkg
// shared constants, operation codes and request/result types of the scheduler
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package mcts_pkg;

  localparam int unsigned MAX_TASKS_DEF = 16;

  localparam int unsigned MODE_W    = 3;
  localparam int unsigned ID_W      = 4;
  localparam int unsigned PRIO_W    = 8;
  localparam int unsigned COUNTER_W = 9;
  localparam int unsigned TOTAL_W   = 5;
  localparam int unsigned DFLT_W    = 8;

  localparam logic [DFLT_W-1:0] DEFAULT_COUNTER_RST = 8'd10;

  // operation codes
  localparam logic [MODE_W-1:0] MODE_CREATE  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ENQUEUE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_DEQUEUE = 3'd2;
  localparam logic [MODE_W-1:0] MODE_TICK    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_PICK    = 3'd4;

  typedef struct packed {
    logic [MODE_W-1:0]    mode;
    logic [ID_W-1:0]      task_id;
    logic [PRIO_W-1:0]    task_priority_in;
    logic [COUNTER_W-1:0] start_counter;
  } mcts_req_t;

  typedef struct packed {
    logic [ID_W-1:0]      chosen_task;
    logic                 chosen_valid;
    logic                 counters_refilled;
    logic                 resched_needed;
    logic [COUNTER_W-1:0] counter_now;
    logic [TOTAL_W-1:0]   queued_total;
    logic                 misuse;
  } mcts_res_t;

endpackage

[design/mcts_pick_cmp.sv]
// ---------------------------------------------------------------------------
// mcts_pick_cmp
// shared compare unit: decides whether a scanned slot beats the best so far
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mcts_pick_cmp #(
  parameter int unsigned AGE_W = 4
) (
  input  logic                           cand_queued_i,
  input  logic [mcts_pkg::COUNTER_W-1:0] cand_cnt_i,
  input  logic [AGE_W-1:0]               cand_age_i,
  input  logic                           have_best_i,
  input  logic [mcts_pkg::COUNTER_W-1:0] best_cnt_i,
  input  logic [AGE_W-1:0]               best_age_i,
  output logic                           take_o
);
  import mcts_pkg::*;

  // larger counter wins, a tie goes to the more recently enqueued slot
  assign take_o = cand_queued_i &&
                  (!have_best_i || (cand_cnt_i > best_cnt_i) ||
                   ((cand_cnt_i == best_cnt_i) && (cand_age_i < best_age_i)));

endmodule

[design/max_counter_task_scheduler.sv]
// ---------------------------------------------------------------------------
// max_counter_task_scheduler
// task table with run queue, tick accounting and largest-counter pick
// ---------------------------------------------------------------------------
//  channel   | ports                       | handshake
//  ----------+-----------------------------+------------------------------
//  request   | start, busy, req_i          | taken when start && !busy
//  result    | result_strobe_o, result_o   | one-cycle strobe, no back-pressure
//  config    | cfg_we_i, cfg_wdata_i       | written when cfg_we_i is high
//
// create, tick and unknown codes: accept, execute, strobe in the next cycle.
// enqueue and dequeue: execute state, then a sweep over the ranks of all slots.
// pick: a scan of all slots through the shared compare unit, then a decide state;
//   a refill adds a sweep over all slots and a second scan.
// busy stays high from acceptance until the strobe; reset clears the whole table.
// the receiver cannot stall, each result is shown for one cycle only.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module max_counter_task_scheduler #(
  parameter int unsigned MAX_TASKS = mcts_pkg::MAX_TASKS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  mcts_pkg::mcts_req_t         req_i,
  output logic                        result_strobe_o,
  output mcts_pkg::mcts_res_t         result_o,
  input  logic                        cfg_we_i,
  input  logic [mcts_pkg::DFLT_W-1:0] cfg_wdata_i
);
  import mcts_pkg::*;

  localparam int unsigned IDX_W   = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned AGE_W   = IDX_W;
  localparam int unsigned COUNT_W = $clog2(MAX_TASKS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_TASKS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_ENQ,
    ST_DEQ,
    ST_SCAN,
    ST_DECIDE,
    ST_REFILL
  } state_e;

  state_e                 state_q;
  mcts_req_t              req_q;
  logic                   ok_q;
  logic [IDX_W-1:0]       tgt_q;
  logic [IDX_W-1:0]       idx_q;
  logic [AGE_W-1:0]       ref_age_q;
  logic                   found_q;
  logic                   refilled_q;
  logic [IDX_W-1:0]       best_idx_q;
  logic [COUNTER_W-1:0]   best_cnt_q;
  logic [AGE_W-1:0]       best_age_q;
  logic [COUNT_W-1:0]     count_q;
  logic [DFLT_W-1:0]      dflt_q;
  logic                   strobe_q;
  mcts_res_t              res_q;

  logic                   present_q [MAX_TASKS];
  logic [COUNTER_W-1:0]   cnt_q     [MAX_TASKS];
  logic [PRIO_W-1:0]      prio_q    [MAX_TASKS];
  logic                   flag_q    [MAX_TASKS];
  logic                   queued_q  [MAX_TASKS];
  logic [AGE_W-1:0]       age_q     [MAX_TASKS];

  // single read port at the sequencer index
  logic                   rd_present;
  logic [COUNTER_W-1:0]   rd_cnt;
  logic [PRIO_W-1:0]      rd_prio;
  logic                   rd_flag;
  logic                   rd_queued;
  logic [AGE_W-1:0]       rd_age;
  logic                   take;
  logic [COUNTER_W-1:0]   refill_val;
  logic [COUNTER_W-1:0]   tick_val;
  logic                   tick_zero;

  assign rd_present = present_q[idx_q];
  assign rd_cnt     = cnt_q[idx_q];
  assign rd_prio    = prio_q[idx_q];
  assign rd_flag    = flag_q[idx_q];
  assign rd_queued  = queued_q[idx_q];
  assign rd_age     = age_q[idx_q];

  assign refill_val = COUNTER_W'(dflt_q) + COUNTER_W'(rd_prio);
  assign tick_zero  = (rd_cnt <= COUNTER_W'(1));
  assign tick_val   = tick_zero ? '0 : (rd_cnt - COUNTER_W'(1));

  mcts_pick_cmp #(
    .AGE_W(AGE_W)
  ) u_cmp (
    .cand_queued_i(rd_queued),
    .cand_cnt_i   (rd_cnt),
    .cand_age_i   (rd_age),
    .have_best_i  (found_q),
    .best_cnt_i   (best_cnt_q),
    .best_age_i   (best_age_q),
    .take_o       (take)
  );

  assign busy            = (state_q != ST_IDLE);
  assign result_strobe_o = strobe_q;
  assign result_o        = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      req_q      <= '0;
      ok_q       <= 1'b0;
      tgt_q      <= '0;
      idx_q      <= '0;
      ref_age_q  <= '0;
      found_q    <= 1'b0;
      refilled_q <= 1'b0;
      best_idx_q <= '0;
      best_cnt_q <= '0;
      best_age_q <= '0;
      count_q    <= '0;
      dflt_q     <= DEFAULT_COUNTER_RST;
      strobe_q   <= 1'b0;
      res_q      <= '0;
      for (int i = 0; i < MAX_TASKS; i++) begin
        present_q[i] <= 1'b0;
        cnt_q[i]     <= '0;
        prio_q[i]    <= '0;
        flag_q[i]    <= 1'b0;
        queued_q[i]  <= 1'b0;
        age_q[i]     <= '0;
      end
    end else begin
      strobe_q <= 1'b0;
      if (cfg_we_i) begin
        dflt_q <= cfg_wdata_i;
      end

      case (state_q)
        ST_IDLE: begin
          if (start) begin
            req_q      <= req_i;
            ok_q       <= (int'(req_i.task_id) < MAX_TASKS);
            tgt_q      <= IDX_W'(req_i.task_id);
            idx_q      <= IDX_W'(req_i.task_id);
            found_q    <= 1'b0;
            refilled_q <= 1'b0;
            state_q    <= ST_EXEC;
          end
        end

        ST_EXEC: begin
          res_q              <= '0;
          res_q.queued_total <= TOTAL_W'(count_q);
          case (req_q.mode)
            MODE_CREATE: begin
              if (ok_q) begin
                present_q[tgt_q] <= 1'b1;
                prio_q[tgt_q]    <= req_q.task_priority_in;
                cnt_q[tgt_q]     <= req_q.start_counter;
                flag_q[tgt_q]    <= 1'b0;
              end
              strobe_q <= 1'b1;
              state_q  <= ST_IDLE;
            end
            MODE_ENQUEUE: begin
              if (!ok_q || rd_queued || !rd_present) begin
                res_q.misuse <= 1'b1;
                strobe_q     <= 1'b1;
                state_q      <= ST_IDLE;
              end else begin
                idx_q   <= '0;
                state_q <= ST_ENQ;
              end
            end
            MODE_DEQUEUE: begin
              if (!ok_q || !rd_queued) begin
                res_q.misuse <= 1'b1;
                strobe_q     <= 1'b1;
                state_q      <= ST_IDLE;
              end else begin
                ref_age_q <= rd_age;
                idx_q     <= '0;
                state_q   <= ST_DEQ;
              end
            end
            MODE_TICK: begin
              if (ok_q) begin
                cnt_q[tgt_q] <= tick_val;
                if (tick_zero) begin
                  flag_q[tgt_q] <= 1'b1;
                end
                res_q.resched_needed <= tick_zero || rd_flag;
                res_q.counter_now    <= tick_val;
              end
              strobe_q <= 1'b1;
              state_q  <= ST_IDLE;
            end
            MODE_PICK: begin
              idx_q   <= '0;
              state_q <= ST_SCAN;
            end
            default: begin
              strobe_q <= 1'b1;
              state_q  <= ST_IDLE;
            end
          endcase
        end

        ST_ENQ: begin
          if (rd_queued) begin
            age_q[idx_q] <= rd_age + AGE_W'(1);
          end
          if (idx_q == LAST_IDX) begin
            queued_q[tgt_q]    <= 1'b1;
            age_q[tgt_q]       <= '0;
            count_q            <= count_q + COUNT_W'(1);
            res_q              <= '0;
            res_q.queued_total <= TOTAL_W'(count_q + COUNT_W'(1));
            strobe_q           <= 1'b1;
            state_q            <= ST_IDLE;
          end else begin
            idx_q <= idx_q + IDX_W'(1);
          end
        end

        ST_DEQ: begin
          // close the gap left by the removed rank
          if (rd_queued && (rd_age > ref_age_q)) begin
            age_q[idx_q] <= rd_age - AGE_W'(1);
          end
          if (idx_q == LAST_IDX) begin
            queued_q[tgt_q]    <= 1'b0;
            age_q[tgt_q]       <= '0;
            count_q            <= count_q - COUNT_W'(1);
            res_q              <= '0;
            res_q.queued_total <= TOTAL_W'(count_q - COUNT_W'(1));
            strobe_q           <= 1'b1;
            state_q            <= ST_IDLE;
          end else begin
            idx_q <= idx_q + IDX_W'(1);
          end
        end

        ST_SCAN: begin
          if (take) begin
            found_q    <= 1'b1;
            best_idx_q <= idx_q;
            best_cnt_q <= rd_cnt;
            best_age_q <= rd_age;
          end
          if (idx_q == LAST_IDX) begin
            state_q <= ST_DECIDE;
          end else begin
            idx_q <= idx_q + IDX_W'(1);
          end
        end

        ST_DECIDE: begin
          if (found_q && (best_cnt_q == '0) && !refilled_q) begin
            refilled_q <= 1'b1;
            idx_q      <= '0;
            state_q    <= ST_REFILL;
          end else begin
            res_q                   <= '0;
            res_q.queued_total      <= TOTAL_W'(count_q);
            res_q.chosen_valid      <= found_q;
            res_q.counters_refilled <= refilled_q;
            if (found_q) begin
              res_q.chosen_task <= ID_W'(best_idx_q);
              res_q.counter_now <= best_cnt_q;
            end
            strobe_q <= 1'b1;
            state_q  <= ST_IDLE;
          end
        end

        ST_REFILL: begin
          if (rd_present) begin
            cnt_q[idx_q] <= refill_val;
          end
          if (idx_q == LAST_IDX) begin
            found_q <= 1'b0;
            idx_q   <= '0;
            state_q <= ST_SCAN;
          end else begin
            idx_q <= idx_q + IDX_W'(1);
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

`include "max_counter_task_scheduler_assert.svh"

  `MCTS_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `MCTS_ASSERT_SAME(a_strobe_after_work, result_strobe_o, $past(busy))
  `MCTS_ASSERT_SAME(a_misuse_no_choice, result_strobe_o && result_o.misuse,
                    !result_o.chosen_valid)
  `MCTS_ASSERT_SAME(a_refill_has_choice, result_strobe_o && result_o.counters_refilled,
                    result_o.chosen_valid)
  `MCTS_ASSERT_SAME(a_count_bound, 1'b1, int'(count_q) <= MAX_TASKS)

endmodule

[tb/tb_max_counter_task_scheduler.sv]
// ---------------------------------------------------------------------------
// tb_max_counter_task_scheduler
// drives create, enqueue, dequeue, tick, pick and unused operation codes into
// the scheduler, keeps its own copy of the task table and run queue to work
// out each result, and checks every strobed result against the oldest one due
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_max_counter_task_scheduler;
  import mcts_pkg::*;

  localparam int unsigned SLOTS        = MAX_TASKS_DEF;
  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int unsigned TAIL_CYCLES  = 60;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam logic [MODE_W-1:0] MODE_LAST_CODE = 3'd7;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  mcts_req_t           req_i = '0;
  logic                result_strobe_o;
  mcts_res_t           result_o;
  logic                cfg_we_i = 1'b0;
  logic [DFLT_W-1:0]   cfg_wdata_i = '0;

  // own copy of the task table and run queue
  logic                 slot_present [SLOTS];
  logic [COUNTER_W-1:0] slot_counter [SLOTS];
  logic [PRIO_W-1:0]    slot_prio    [SLOTS];
  logic                 slot_resched [SLOTS];
  logic                 slot_queued  [SLOTS];
  logic [ID_W-1:0]      slot_rank    [SLOTS];
  logic [TOTAL_W-1:0]   queued_count;
  logic [DFLT_W-1:0]    base_slice;

  mcts_res_t   pending_results [$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned sender_idle_pct = 0;

  max_counter_task_scheduler dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .req_i           (req_i),
    .result_strobe_o (result_strobe_o),
    .result_o        (result_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // queued slot with the largest counter, newest wins a tie; -1 when empty
  function automatic int best_queued_slot();
    int best;
    best = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_queued[i]) begin
        if (best < 0 || slot_counter[i] > slot_counter[best] ||
            (slot_counter[i] == slot_counter[best] && slot_rank[i] < slot_rank[best]))
          best = i;
      end
    end
    return best;
  endfunction

  function automatic mcts_res_t schedule_outcome(mcts_req_t r);
    mcts_res_t res;
    int        b;
    int        id;
    res = '0;
    id  = r.task_id;
    case (r.mode)
      MODE_CREATE: begin
        slot_present[id] = 1'b1;
        slot_prio[id]    = r.task_priority_in;
        slot_counter[id] = r.start_counter;
        slot_resched[id] = 1'b0;
      end
      MODE_ENQUEUE: begin
        if (slot_queued[id] || !slot_present[id]) begin
          res.misuse = 1'b1;
        end else begin
          for (int i = 0; i < SLOTS; i++)
            if (slot_queued[i]) slot_rank[i] = slot_rank[i] + 1'b1;
          slot_queued[id] = 1'b1;
          slot_rank[id]   = '0;
          queued_count    = queued_count + 1'b1;
        end
      end
      MODE_DEQUEUE: begin
        if (!slot_queued[id]) begin
          res.misuse = 1'b1;
        end else begin
          for (int i = 0; i < SLOTS; i++)
            if (slot_queued[i] && slot_rank[i] > slot_rank[id])
              slot_rank[i] = slot_rank[i] - 1'b1;
          slot_queued[id] = 1'b0;
          slot_rank[id]   = '0;
          queued_count    = queued_count - 1'b1;
        end
      end
      MODE_TICK: begin
        if (slot_counter[id] <= 1) begin
          slot_counter[id] = '0;
          slot_resched[id] = 1'b1;
        end else begin
          slot_counter[id] = slot_counter[id] - 1'b1;
        end
        res.resched_needed = slot_resched[id];
        res.counter_now    = slot_counter[id];
      end
      MODE_PICK: begin
        b = best_queued_slot();
        if (b >= 0) begin
          if (slot_counter[b] == 0) begin
            for (int i = 0; i < SLOTS; i++)
              if (slot_present[i])
                slot_counter[i] = {1'b0, base_slice} + {1'b0, slot_prio[i]};
            res.counters_refilled = 1'b1;
            b = best_queued_slot();
          end
          res.chosen_task  = b[ID_W-1:0];
          res.chosen_valid = 1'b1;
          res.counter_now  = slot_counter[b];
        end
      end
      default: ;
    endcase
    res.queued_total = queued_count;
    return res;
  endfunction

  task automatic note_failure(string what, mcts_res_t exp, mcts_res_t got);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("%0t %s: expected task=%0d valid=%0b refill=%0b resched=%0b cnt=%0d total=%0d misuse=%0b",
               $time, what, exp.chosen_task, exp.chosen_valid, exp.counters_refilled,
               exp.resched_needed, exp.counter_now, exp.queued_total, exp.misuse);
      $display("    got task=%0d valid=%0b refill=%0b resched=%0b cnt=%0d total=%0d misuse=%0b",
               got.chosen_task, got.chosen_valid, got.counters_refilled,
               got.resched_needed, got.counter_now, got.queued_total, got.misuse);
    end
  endtask

  always @(posedge clk_i) begin
    mcts_res_t exp;
    string     diff;
    if (rst_ni && result_strobe_o === 1'b1) begin
      if (pending_results.size() == 0) begin
        note_failure("result with no request outstanding", '0, result_o);
      end else begin
        exp  = pending_results.pop_front();
        diff = "";
        if (result_o.chosen_task !== exp.chosen_task)             diff = {diff, " chosen_task"};
        if (result_o.chosen_valid !== exp.chosen_valid)           diff = {diff, " chosen_valid"};
        if (result_o.counters_refilled !== exp.counters_refilled) diff = {diff, " refilled"};
        if (result_o.resched_needed !== exp.resched_needed)       diff = {diff, " resched"};
        if (result_o.counter_now !== exp.counter_now)             diff = {diff, " counter_now"};
        if (result_o.queued_total !== exp.queued_total)           diff = {diff, " queued_total"};
        if (result_o.misuse !== exp.misuse)                       diff = {diff, " misuse"};
        if (diff != "") note_failure({"mismatch in", diff}, exp, result_o);
      end
    end
  end

  // called at a rising edge; returns at the edge that took the request
  task automatic send_request(mcts_req_t r);
    int unsigned gap;
    gap = 0;
    while (gap < 24 && $urandom_range(0, 99) < sender_idle_pct) gap++;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy !== 1'b0);
    pending_results.push_back(schedule_outcome(r));
  endtask

  task automatic send_op(logic [MODE_W-1:0] mode, logic [ID_W-1:0] id,
                         logic [PRIO_W-1:0] prio, logic [COUNTER_W-1:0] cnt);
    mcts_req_t r;
    r.mode             = mode;
    r.task_id          = id;
    r.task_priority_in = prio;
    r.start_counter    = cnt;
    send_request(r);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  // only while idle, see drain_results
  task automatic write_base_slice(logic [DFLT_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    base_slice = value;
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [ID_W-1:0] random_slot(bit want_queued);
    int unsigned     first;
    logic [ID_W-1:0] id;
    first = $urandom_range(0, SLOTS - 1);
    for (int k = 0; k < SLOTS; k++) begin
      id = ID_W'((first + k) % SLOTS);
      if (want_queued ? slot_queued[id] : (slot_present[id] && !slot_queued[id]))
        return id;
    end
    return ID_W'($urandom);
  endfunction

  function automatic mcts_req_t random_request();
    mcts_req_t   r;
    int unsigned sel;
    bool_guided: begin end
    r.task_priority_in = ($urandom_range(0, 9) == 0) ? PRIO_W'($urandom)
                                                      : PRIO_W'($urandom_range(0, 6));
    r.start_counter    = ($urandom_range(0, 9) == 0) ? COUNTER_W'($urandom)
                                                      : COUNTER_W'($urandom_range(0, 6));
    r.task_id = ID_W'($urandom);
    sel = $urandom_range(0, 99);
    if (sel < 14) begin
      r.mode = MODE_CREATE;
    end else if (sel < 34) begin
      r.mode = MODE_ENQUEUE;
      if ($urandom_range(0, 9) < 8) r.task_id = random_slot(1'b0);
    end else if (sel < 48) begin
      r.mode = MODE_DEQUEUE;
      if ($urandom_range(0, 9) < 8) r.task_id = random_slot(1'b1);
    end else if (sel < 73) begin
      r.mode = MODE_TICK;
      if ($urandom_range(0, 9) < 7) r.task_id = random_slot(1'b1);
    end else if (sel < 95) begin
      r.mode = MODE_PICK;
    end else begin
      r.mode = MODE_W'($urandom_range(int'(MODE_PICK) + 1, int'(MODE_LAST_CODE)));
    end
    return r;
  endfunction

  task automatic test_create_and_tick();
    send_op(MODE_CREATE, 4'd15, 8'd255, 9'd511);
    send_op(MODE_TICK,   4'd15, 8'd0,   9'd0);
    send_op(MODE_CREATE, 4'd0,  8'd0,   9'd1);
    send_op(MODE_TICK,   4'd0,  8'd0,   9'd0);
    // already at zero: stays zero, flag stays set
    send_op(MODE_TICK,   4'd0,  8'd0,   9'd0);
    // tick of a slot never created
    send_op(MODE_TICK,   4'd7,  8'd0,   9'd0);
    for (int m = int'(MODE_PICK) + 1; m <= int'(MODE_LAST_CODE); m++)
      send_op(MODE_W'(m), 4'd9, 8'd255, 9'd511);
  endtask

  task automatic test_queue_misuse();
    send_op(MODE_ENQUEUE, 4'd3,  8'd0, 9'd0);
    send_op(MODE_DEQUEUE, 4'd0,  8'd0, 9'd0);
    send_op(MODE_PICK,    4'd0,  8'd0, 9'd0);
    send_op(MODE_ENQUEUE, 4'd0,  8'd0, 9'd0);
    send_op(MODE_ENQUEUE, 4'd0,  8'd0, 9'd0);
    send_op(MODE_ENQUEUE, 4'd15, 8'd0, 9'd0);
    // re-create while queued keeps the rank
    send_op(MODE_CREATE,  4'd15, 8'd1, 9'd5);
    send_op(MODE_PICK,    4'd0,  8'd0, 9'd0);
    send_op(MODE_DEQUEUE, 4'd0,  8'd0, 9'd0);
  endtask

  task automatic test_refill_extremes();
    drain_results();
    write_base_slice(8'd0);
    send_op(MODE_CREATE,  4'd15, 8'd0, 9'd0);
    send_op(MODE_CREATE,  4'd0,  8'd0, 9'd0);
    send_op(MODE_ENQUEUE, 4'd0,  8'd0, 9'd0);
    // refill leaves everything at zero, newest slot still chosen
    send_op(MODE_PICK,    4'd0,  8'd0, 9'd0);
    drain_results();
    write_base_slice(8'd1);
    send_op(MODE_PICK,    4'd0,  8'd0, 9'd0);
    drain_results();
    write_base_slice(8'd255);
    send_op(MODE_CREATE,  4'd0,  8'd255, 9'd0);
    send_op(MODE_CREATE,  4'd15, 8'd255, 9'd0);
    send_op(MODE_PICK,    4'd0,  8'd0,   9'd0);
  endtask

  task automatic test_random_traffic(int unsigned n_items, int unsigned idle_pct,
                                     logic [DFLT_W-1:0] slice);
    drain_results();
    write_base_slice(slice);
    sender_idle_pct = idle_pct;
    for (int n = 0; n < n_items; n++) send_request(random_request());
  endtask

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      slot_present[i] = 1'b0;
      slot_counter[i] = '0;
      slot_prio[i]    = '0;
      slot_resched[i] = 1'b0;
      slot_queued[i]  = 1'b0;
      slot_rank[i]    = '0;
    end
    queued_count = '0;
    base_slice   = DEFAULT_COUNTER_RST;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    sender_idle_pct = 28;
    test_create_and_tick();
    test_queue_misuse();
    test_refill_extremes();
    test_random_traffic(150, 28, DFLT_W'($urandom_range(1, 20)));
    test_random_traffic(150, 53, 8'd255);
    test_random_traffic(150, 0,  DFLT_W'($urandom));
    drain_results();

    error_count += pending_results.size();
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
